// ===== hdl/lgpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Light gate pre/post extender package
// Beat types for the sample and result channels, register map constants.
// ----------------------------------------------------------------------------
package lgpe_pkg;

	localparam int WORD_W  = 32;
	localparam int PRE_W   = 7;
	localparam int POST_W  = 16;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Register indexes; byte address is four times the index.
	localparam logic [1:0] REG_LIGHT_MASK = 2'd0;
	localparam logic [1:0] REG_PRE_SCANS  = 2'd1;
	localparam logic [1:0] REG_POST_SCANS = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] sample_word;
		logic              start_of_record;
	} in_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] word_out;
		logic              out_valid;
	} out_beat_t;

endpackage

// ===== hdl/lgpe_look.sv =====
// ----------------------------------------------------------------------------
// Light gate lookahead
// Decides whether a lit word lies ahead of the leaving word within the
// pre-lighting window, stopping at the first record start.
// ----------------------------------------------------------------------------
module lgpe_look #(
	parameter int DELAY = 64
) (
	input  logic [DELAY-1:0][lgpe_pkg::WORD_W-1:0] words,
	input  logic [DELAY-1:0]                       starts,
	input  logic [lgpe_pkg::WORD_W-1:0]            light_mask,
	input  logic [lgpe_pkg::PRE_W-1:0]             pre_scans,
	output logic                                   ahead
);

	logic [DELAY-1:0] lit_only;
	logic [DELAY-1:0] stop_vec;
	logic [DELAY-1:0] first_stop;

	// Bit j stands for the word j+1 places ahead of the leaving word.
	always_comb begin
		for (int j = 0; j < DELAY; j++) begin
			lit_only[j] = (|(words[j] & light_mask)) && !starts[j];
			stop_vec[j] = ((|(words[j] & light_mask)) || starts[j])
				&& ((j + 1) <= int'(pre_scans));
		end
	end

	// Isolate the nearest stop: either a lit word or a record start.
	assign first_stop = stop_vec & (~stop_vec + {{(DELAY-1){1'b0}}, 1'b1});
	assign ahead      = |(first_stop & lit_only);

endmodule

// ===== hdl/light_gate_pre_post_extender.sv =====
// ----------------------------------------------------------------------------
// Light gate pre/post extender
// Delays a stream of digital output words by DELAY beats and widens every
// pulse on the masked light line: pre-lighting through lookahead along the
// delay line, post-lighting through a hold counter.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  in        sink       in_valid / in_ready            in_data  (in_beat_t)
//  out       source     out_valid / out_ready          out_data (out_beat_t)
//  config    APB slave  psel penable pwrite, pready=1  paddr pwdata prdata
//
// One beat is taken per clock unless a waiting result is not taken; each
// result is registered in the cycle after its beat; its word entered DELAY
// beats earlier. The lookahead over the delay line is one find-first pass.
// Reset clears the configuration registers, hold counter, fill count and
// result valid flag. A stalled result stops intake only while out_ready is low.
module light_gate_pre_post_extender #(
	parameter int DELAY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lgpe_pkg::in_beat_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lgpe_pkg::out_beat_t             out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lgpe_pkg::ADDR_W-1:0]     paddr,
	input  logic [lgpe_pkg::DATA_W-1:0]     pwdata,
	output logic [lgpe_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int FILL_W = $clog2(DELAY + 1);

	logic [lgpe_pkg::WORD_W-1:0] light_mask_q;
	logic [lgpe_pkg::PRE_W-1:0]  pre_scans_q;
	logic [lgpe_pkg::POST_W-1:0] post_scans_q;

	lgpe_pkg::in_beat_t          line_q [DELAY];
	logic [lgpe_pkg::POST_W-1:0] hold_q;
	logic [FILL_W-1:0]           fill_q;
	logic                        out_valid_q;
	lgpe_pkg::out_beat_t         out_data_q;

	logic                                   accept;
	logic                                   wr_en;
	logic [1:0]                             reg_idx;
	lgpe_pkg::in_beat_t                     cur;
	logic [DELAY-1:0][lgpe_pkg::WORD_W-1:0] ahead_words;
	logic [DELAY-1:0]                       ahead_starts;
	logic                                   ahead;
	logic                                   cur_lit;
	logic [lgpe_pkg::POST_W-1:0]            hold_base;
	logic [lgpe_pkg::POST_W-1:0]            hold_nxt;
	logic [lgpe_pkg::WORD_W-1:0]            word_nxt;
	logic                                   filled;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_mask_q <= '0;
			pre_scans_q  <= '0;
			post_scans_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				lgpe_pkg::REG_LIGHT_MASK: light_mask_q <= pwdata;
				lgpe_pkg::REG_PRE_SCANS:  pre_scans_q  <= pwdata[lgpe_pkg::PRE_W-1:0];
				lgpe_pkg::REG_POST_SCANS: post_scans_q <= pwdata[lgpe_pkg::POST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			lgpe_pkg::REG_LIGHT_MASK: prdata = light_mask_q;
			lgpe_pkg::REG_PRE_SCANS:
				prdata = {{(lgpe_pkg::DATA_W-lgpe_pkg::PRE_W){1'b0}}, pre_scans_q};
			lgpe_pkg::REG_POST_SCANS:
				prdata = {{(lgpe_pkg::DATA_W-lgpe_pkg::POST_W){1'b0}}, post_scans_q};
			default: prdata = '0;
		endcase
	end

	// Intake is held off only by a result that is waiting and not taken.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Delay line; the oldest entry is the word that leaves on this beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_q[0] <= in_data;
			for (int i = 1; i < DELAY; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign cur = line_q[DELAY-1];

	// The word one place ahead of the leaving one is the next-oldest stored
	// entry; the farthest lookahead position is the incoming beat.
	for (genvar j = 0; j < DELAY; j++) begin : g_ahead
		if (j == DELAY - 1) begin : g_in
			assign ahead_words[j]  = in_data.sample_word;
			assign ahead_starts[j] = in_data.start_of_record;
		end else begin : g_line
			assign ahead_words[j]  = line_q[DELAY-2-j].sample_word;
			assign ahead_starts[j] = line_q[DELAY-2-j].start_of_record;
		end
	end

	lgpe_look #(
		.DELAY(DELAY)
	) u_look (
		.words      (ahead_words),
		.starts     (ahead_starts),
		.light_mask (light_mask_q),
		.pre_scans  (pre_scans_q),
		.ahead      (ahead)
	);

	assign filled  = (fill_q == FILL_W'(DELAY));
	assign cur_lit = |(cur.sample_word & light_mask_q);

	always_comb begin
		hold_base = cur.start_of_record ? '0 : hold_q;
		word_nxt  = cur.sample_word;
		hold_nxt  = hold_base;
		if (cur_lit || ahead) begin
			word_nxt = cur.sample_word | light_mask_q;
			hold_nxt = (post_scans_q != '0) ? post_scans_q - 1'b1 : '0;
		end else if (hold_base != '0) begin
			word_nxt = cur.sample_word | light_mask_q;
			hold_nxt = hold_base - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (filled) begin
					hold_q <= hold_nxt;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.word_out  <= filled ? word_nxt : '0;
			out_data_q.out_valid <= filled;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hdl/lgpe_chk.sv =====
// ----------------------------------------------------------------------------
// Light gate pre/post extender port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module lgpe_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input lgpe_pkg::out_beat_t out_data,
	input logic                pready
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// With nothing waiting at the output, intake is open.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// Every accepted input beat produces a result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after accepted beat");

	// While the delay line fills, the result word is zero.
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.out_valid |-> out_data.word_out == '0)
		else $error("nonzero word during fill");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind light_gate_pre_post_extender lgpe_chk u_lgpe_chk (.*);
